// ===== design/rect_placement_table_top_macros.svh =====
// Assertion macros used by the checker file.
`ifndef RECT_PLACEMENT_TABLE_TOP_MACROS_SVH
`define RECT_PLACEMENT_TABLE_TOP_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define RPT_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("rpt assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define RPT_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("rpt assertion failed");

`endif

// ===== design/rpt_pkg.sv =====
package rpt_pkg;

  // Default sizes.
  localparam int RPT_TABLE_DEPTH = 16;
  localparam int RPT_COORD_BITS  = 12;

  // Fixed field widths.
  localparam int ID_W    = 16;
  localparam int SCR_W   = 11;
  localparam int STEP_W  = 8;
  localparam int STAT_W  = 3;
  localparam int PLACE_W = 11;
  localparam int CMD_W   = 2;
  localparam int CFG_W   = 11;
  localparam int CIDX_W  = 2;

  // Smallest coordinate width that still holds every grid position.
  localparam int GRID_CW = PLACE_W + 1;

  // Commands.
  localparam logic [CMD_W-1:0] CMD_CHECK    = 2'd0;
  localparam logic [CMD_W-1:0] CMD_ADD      = 2'd1;
  localparam logic [CMD_W-1:0] CMD_REMOVE   = 2'd2;
  localparam logic [CMD_W-1:0] CMD_VALIDATE = 2'd3;

  // Result status codes.
  localparam logic [STAT_W-1:0] ST_OK       = 3'd0;
  localparam logic [STAT_W-1:0] ST_BOUNDS   = 3'd1;
  localparam logic [STAT_W-1:0] ST_OVERLAP  = 3'd2;
  localparam logic [STAT_W-1:0] ST_FULL     = 3'd3;
  localparam logic [STAT_W-1:0] ST_NOTFOUND = 3'd4;

  // Configuration register indexes.
  localparam logic [CIDX_W-1:0] REG_SCREEN_WIDTH  = 2'd0;
  localparam logic [CIDX_W-1:0] REG_SCREEN_HEIGHT = 2'd1;
  localparam logic [CIDX_W-1:0] REG_GRID_STEP     = 2'd2;

  // Reset values.
  localparam logic [SCR_W-1:0]  RST_SCREEN_WIDTH  = 11'd1024;
  localparam logic [SCR_W-1:0]  RST_SCREEN_HEIGHT = 11'd600;
  localparam logic [STEP_W-1:0] RST_GRID_STEP     = 8'd8;
  localparam logic [ID_W-1:0]   RST_NEXT_ID       = 16'd1;
  localparam logic [ID_W-1:0]   LAST_ID           = 16'hFFFF;

  // Sequencer states.
  typedef enum logic [3:0] {
    S_IDLE,
    S_PROBE,
    S_EVAL,
    S_GRID,
    S_VLOAD,
    S_RM_FIND,
    S_RM_SEL,
    S_STORE,
    S_FINISH
  } state_t;

  // What the current probe is for.
  typedef enum logic [1:0] {
    M_CHECK,
    M_PREF,
    M_GRID,
    M_VALID
  } mode_t;

  // Per-cell control.
  typedef struct packed {
    logic load;
    logic shift;
  } cell_ctl_t;

endpackage

// ===== design/rpt_cell.sv =====
// One table entry. It loads a new rectangle, takes its right neighbor's entry
// when the table closes a gap, and compares itself against the probe.
module rpt_cell #(
  parameter int CW = rpt_pkg::GRID_CW
) (
  input  logic                     clk,
  input  rpt_pkg::cell_ctl_t       ctl,
  input  logic [rpt_pkg::ID_W-1:0] wr_id,
  input  logic signed [CW-1:0]     wr_x,
  input  logic signed [CW-1:0]     wr_y,
  input  logic signed [CW-1:0]     wr_w,
  input  logic signed [CW-1:0]     wr_h,
  input  logic [rpt_pkg::ID_W-1:0] nb_id,
  input  logic signed [CW-1:0]     nb_x,
  input  logic signed [CW-1:0]     nb_y,
  input  logic signed [CW-1:0]     nb_w,
  input  logic signed [CW-1:0]     nb_h,
  input  logic [rpt_pkg::ID_W-1:0] pr_skip,
  input  logic signed [CW-1:0]     pr_x,
  input  logic signed [CW-1:0]     pr_y,
  input  logic signed [CW-1:0]     pr_w,
  input  logic signed [CW-1:0]     pr_h,
  input  logic [rpt_pkg::ID_W-1:0] key,
  output logic [rpt_pkg::ID_W-1:0] ent_id,
  output logic signed [CW-1:0]     ent_x,
  output logic signed [CW-1:0]     ent_y,
  output logic signed [CW-1:0]     ent_w,
  output logic signed [CW-1:0]     ent_h,
  output logic                     hit,
  output logic                     match
);

  localparam int SW = CW + 1;

  logic [rpt_pkg::ID_W-1:0] id_r, id_nxt;
  logic signed [CW-1:0]     x_r, x_nxt, y_r, y_nxt, w_r, w_nxt, h_r, h_nxt;
  logic signed [SW-1:0]     a_x1, a_y1, b_x1, b_y1;

  // Entry update: a load wins over a shift.
  always_comb begin
    id_nxt = id_r;
    x_nxt  = x_r;
    y_nxt  = y_r;
    w_nxt  = w_r;
    h_nxt  = h_r;
    if (ctl.load) begin
      id_nxt = wr_id;
      x_nxt  = wr_x;
      y_nxt  = wr_y;
      w_nxt  = wr_w;
      h_nxt  = wr_h;
    end else if (ctl.shift) begin
      id_nxt = nb_id;
      x_nxt  = nb_x;
      y_nxt  = nb_y;
      w_nxt  = nb_w;
      h_nxt  = nb_h;
    end
  end

  always_ff @(posedge clk) begin
    id_r <= id_nxt;
    x_r  <= x_nxt;
    y_r  <= y_nxt;
    w_r  <= w_nxt;
    h_r  <= h_nxt;
  end

  // Half-open overlap on both axes, skipping the ignored id.
  assign a_x1 = SW'(pr_x) + SW'(pr_w);
  assign a_y1 = SW'(pr_y) + SW'(pr_h);
  assign b_x1 = SW'(x_r) + SW'(w_r);
  assign b_y1 = SW'(y_r) + SW'(h_r);

  assign hit = (id_r != pr_skip) &&
               !(a_x1 <= SW'(x_r) || b_x1 <= SW'(pr_x) ||
                 a_y1 <= SW'(y_r) || b_y1 <= SW'(pr_y));
  assign match = (id_r == key);

  assign ent_id = id_r;
  assign ent_x  = x_r;
  assign ent_y  = y_r;
  assign ent_w  = w_r;
  assign ent_h  = h_r;

endmodule

// ===== design/rect_placement_table_top.sv =====
// Rectangle placement table. Start is taken when busy is low; exactly one
// result follows, shown for one cycle with out_valid and no way to hold it
// off, so the receiver must sample it then. Busy stays high until that cycle
// ends. The entries live in a row of cells that all compare against one probe
// rectangle at once; each probe is a cell compare, then a first-hit pick. An
// add whose preferred spot is taken may walk the grid; the grid walk is the
// long case and depends on screen size, rectangle size and grid step.
module rect_placement_table_top #(
  parameter int TABLE_DEPTH = rpt_pkg::RPT_TABLE_DEPTH,
  parameter int COORD_BITS  = rpt_pkg::RPT_COORD_BITS
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic [rpt_pkg::CMD_W-1:0]     in_command,
  input  logic [rpt_pkg::ID_W-1:0]      in_item_id,
  input  logic signed [COORD_BITS-1:0]  in_rect_x,
  input  logic signed [COORD_BITS-1:0]  in_rect_y,
  input  logic signed [COORD_BITS-1:0]  in_rect_w,
  input  logic signed [COORD_BITS-1:0]  in_rect_h,
  input  logic                          cfg_we,
  input  logic [rpt_pkg::CIDX_W-1:0]    cfg_index,
  input  logic [rpt_pkg::CFG_W-1:0]     cfg_wdata,
  output logic                          out_valid,
  output logic [rpt_pkg::STAT_W-1:0]    out_status,
  output logic [rpt_pkg::ID_W-1:0]      out_rect_id,
  output logic [rpt_pkg::ID_W-1:0]      out_hit_id,
  output logic [rpt_pkg::PLACE_W-1:0]   out_placed_x,
  output logic [rpt_pkg::PLACE_W-1:0]   out_placed_y
);

  localparam int CW   = (COORD_BITS > rpt_pkg::GRID_CW) ? COORD_BITS : rpt_pkg::GRID_CW;
  localparam int AW   = CW + 2;
  localparam int SCW  = AW + 1;
  localparam int CNTW = $clog2(TABLE_DEPTH + 1);
  localparam int IW   = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

  // Control and configuration state.
  rpt_pkg::state_t           state_r, state_nxt;
  rpt_pkg::mode_t            mode_r, mode_nxt;
  logic [CNTW-1:0]           count_r, count_nxt;
  logic [rpt_pkg::ID_W-1:0]  nfid_r, nfid_nxt;
  logic [rpt_pkg::SCR_W-1:0] sw_r, sw_nxt, sh_r, sh_nxt;
  logic [rpt_pkg::STEP_W-1:0] step_r, step_nxt;

  // Working registers.
  logic [rpt_pkg::ID_W-1:0]  iid_r, iid_nxt;
  logic signed [CW-1:0]      rx_r, rx_nxt, ry_r, ry_nxt, rw_r, rw_nxt, rh_r, rh_nxt;
  logic [rpt_pkg::ID_W-1:0]  pr_skip_r, pr_skip_nxt;
  logic signed [CW-1:0]      pr_x_r, pr_x_nxt, pr_y_r, pr_y_nxt;
  logic signed [CW-1:0]      pr_w_r, pr_w_nxt, pr_h_r, pr_h_nxt;
  logic signed [AW-1:0]      gx_r, gx_nxt, gy_r, gy_nxt;
  logic [SCW-1:0]            score_r, score_nxt, best_r, best_nxt;
  logic signed [CW-1:0]      bx_r, bx_nxt, by_r, by_nxt;
  logic                      found_r, found_nxt;
  logic [IW-1:0]             vidx_r, vidx_nxt;
  logic [TABLE_DEPTH-1:0]    hvec_r, hvec_nxt, mvec_r, mvec_nxt;
  logic                      bad_r, bad_nxt;

  // Result registers.
  logic [rpt_pkg::STAT_W-1:0]  res_st_r, res_st_nxt;
  logic [rpt_pkg::ID_W-1:0]    res_mid_r, res_mid_nxt, res_oid_r, res_oid_nxt;
  logic [rpt_pkg::PLACE_W-1:0] res_px_r, res_px_nxt, res_py_r, res_py_nxt;

  // Cell row.
  logic [rpt_pkg::ID_W-1:0] ent_id [TABLE_DEPTH];
  logic signed [CW-1:0]     ent_x [TABLE_DEPTH];
  logic signed [CW-1:0]     ent_y [TABLE_DEPTH];
  logic signed [CW-1:0]     ent_w [TABLE_DEPTH];
  logic signed [CW-1:0]     ent_h [TABLE_DEPTH];
  logic [rpt_pkg::ID_W-1:0] nb_id [TABLE_DEPTH];
  logic signed [CW-1:0]     nb_x [TABLE_DEPTH];
  logic signed [CW-1:0]     nb_y [TABLE_DEPTH];
  logic signed [CW-1:0]     nb_w [TABLE_DEPTH];
  logic signed [CW-1:0]     nb_h [TABLE_DEPTH];
  rpt_pkg::cell_ctl_t       ctl [TABLE_DEPTH];
  logic [TABLE_DEPTH-1:0]   hit, match, valid;

  logic           load_en, shift_en;
  logic [IW-1:0]  shift_idx;

  // Probe helpers.
  logic signed [AW-1:0] sw_e, sh_e, lim_x, lim_y, step_e, dx, dy;
  logic [SCW-1:0]       score_now;
  logic                 bad_now, probe_ok;
  logic [rpt_pkg::ID_W-1:0] first_hit_id;
  logic                 rm_any;
  logic [IW-1:0]        rm_idx;
  logic                 accept;

  for (genvar g = 0; g < TABLE_DEPTH; g++) begin : g_cell
    if (g < TABLE_DEPTH - 1) begin : g_nb
      assign nb_id[g] = ent_id[g+1];
      assign nb_x[g]  = ent_x[g+1];
      assign nb_y[g]  = ent_y[g+1];
      assign nb_w[g]  = ent_w[g+1];
      assign nb_h[g]  = ent_h[g+1];
    end else begin : g_end
      assign nb_id[g] = ent_id[g];
      assign nb_x[g]  = ent_x[g];
      assign nb_y[g]  = ent_y[g];
      assign nb_w[g]  = ent_w[g];
      assign nb_h[g]  = ent_h[g];
    end

    assign valid[g]     = (CNTW'(g) < count_r);
    assign ctl[g].load  = load_en && (CNTW'(g) == count_r);
    assign ctl[g].shift = shift_en && (CNTW'(g) >= CNTW'(shift_idx));

    rpt_cell #(.CW(CW)) u_cell (
      .clk     (clk),
      .ctl     (ctl[g]),
      .wr_id   (nfid_r),
      .wr_x    (bx_r),
      .wr_y    (by_r),
      .wr_w    (rw_r),
      .wr_h    (rh_r),
      .nb_id   (nb_id[g]),
      .nb_x    (nb_x[g]),
      .nb_y    (nb_y[g]),
      .nb_w    (nb_w[g]),
      .nb_h    (nb_h[g]),
      .pr_skip (pr_skip_r),
      .pr_x    (pr_x_r),
      .pr_y    (pr_y_r),
      .pr_w    (pr_w_r),
      .pr_h    (pr_h_r),
      .key     (iid_r),
      .ent_id  (ent_id[g]),
      .ent_x   (ent_x[g]),
      .ent_y   (ent_y[g]),
      .ent_w   (ent_w[g]),
      .ent_h   (ent_h[g]),
      .hit     (hit[g]),
      .match   (match[g])
    );
  end

  // Screen limits and grid arithmetic.
  assign sw_e    = $signed(AW'(sw_r));
  assign sh_e    = $signed(AW'(sh_r));
  assign lim_x   = sw_e - AW'(rw_r);
  assign lim_y   = sh_e - AW'(rh_r);
  assign step_e  = (step_r == '0) ? AW'(1) : $signed(AW'(step_r));
  assign dx      = gx_r - AW'(rx_r);
  assign dy      = gy_r - AW'(ry_r);
  assign score_now = SCW'(dx < 0 ? -dx : dx) + SCW'(dy < 0 ? -dy : dy);

  assign bad_now = (pr_x_r < 0) || (pr_y_r < 0) || (pr_w_r <= 0) || (pr_h_r <= 0) ||
                   (AW'(pr_x_r) + AW'(pr_w_r) > sw_e) ||
                   (AW'(pr_y_r) + AW'(pr_h_r) > sh_e);
  assign probe_ok = !bad_r && (hvec_r == '0);

  // First hit and first match in table order.
  always_comb begin
    first_hit_id = '0;
    rm_any       = 1'b0;
    rm_idx       = '0;
    for (int i = TABLE_DEPTH - 1; i >= 0; i--) begin
      if (hvec_r[i]) begin
        first_hit_id = ent_id[i];
      end
      if (mvec_r[i]) begin
        rm_any = 1'b1;
        rm_idx = IW'(i);
      end
    end
  end

  assign busy   = (state_r != rpt_pkg::S_IDLE);
  assign accept = start && !busy;

  // Sequencer.
  always_comb begin
    state_nxt   = state_r;
    mode_nxt    = mode_r;
    count_nxt   = count_r;
    nfid_nxt    = nfid_r;
    sw_nxt      = sw_r;
    sh_nxt      = sh_r;
    step_nxt    = step_r;
    iid_nxt     = iid_r;
    rx_nxt      = rx_r;
    ry_nxt      = ry_r;
    rw_nxt      = rw_r;
    rh_nxt      = rh_r;
    pr_skip_nxt = pr_skip_r;
    pr_x_nxt    = pr_x_r;
    pr_y_nxt    = pr_y_r;
    pr_w_nxt    = pr_w_r;
    pr_h_nxt    = pr_h_r;
    gx_nxt      = gx_r;
    gy_nxt      = gy_r;
    score_nxt   = score_r;
    best_nxt    = best_r;
    bx_nxt      = bx_r;
    by_nxt      = by_r;
    found_nxt   = found_r;
    vidx_nxt    = vidx_r;
    hvec_nxt    = hvec_r;
    mvec_nxt    = mvec_r;
    bad_nxt     = bad_r;
    res_st_nxt  = res_st_r;
    res_mid_nxt = res_mid_r;
    res_oid_nxt = res_oid_r;
    res_px_nxt  = res_px_r;
    res_py_nxt  = res_py_r;
    load_en     = 1'b0;
    shift_en    = 1'b0;
    shift_idx   = rm_idx;

    // Configuration writes; unknown indexes are dropped.
    if (cfg_we) begin
      case (cfg_index)
        rpt_pkg::REG_SCREEN_WIDTH:  sw_nxt = cfg_wdata;
        rpt_pkg::REG_SCREEN_HEIGHT: sh_nxt = cfg_wdata;
        rpt_pkg::REG_GRID_STEP:     step_nxt = cfg_wdata[rpt_pkg::STEP_W-1:0];
        default: ;
      endcase
    end

    case (state_r)
      rpt_pkg::S_IDLE: begin
        if (accept) begin
          iid_nxt     = in_item_id;
          rx_nxt      = CW'(in_rect_x);
          ry_nxt      = CW'(in_rect_y);
          rw_nxt      = CW'(in_rect_w);
          rh_nxt      = CW'(in_rect_h);
          pr_x_nxt    = CW'(in_rect_x);
          pr_y_nxt    = CW'(in_rect_y);
          pr_w_nxt    = CW'(in_rect_w);
          pr_h_nxt    = CW'(in_rect_h);
          res_st_nxt  = rpt_pkg::ST_OK;
          res_mid_nxt = '0;
          res_oid_nxt = '0;
          res_px_nxt  = '0;
          res_py_nxt  = '0;
          vidx_nxt    = '0;
          case (in_command)
            rpt_pkg::CMD_CHECK: begin
              pr_skip_nxt = in_item_id;
              mode_nxt    = rpt_pkg::M_CHECK;
              state_nxt   = rpt_pkg::S_PROBE;
            end
            rpt_pkg::CMD_ADD: begin
              pr_skip_nxt = '0;
              mode_nxt    = rpt_pkg::M_PREF;
              if (count_r >= CNTW'(TABLE_DEPTH)) begin
                res_st_nxt = rpt_pkg::ST_FULL;
                state_nxt  = rpt_pkg::S_FINISH;
              end else begin
                state_nxt = rpt_pkg::S_PROBE;
              end
            end
            rpt_pkg::CMD_REMOVE: begin
              state_nxt = rpt_pkg::S_RM_FIND;
            end
            default: begin
              mode_nxt  = rpt_pkg::M_VALID;
              state_nxt = (count_r == '0) ? rpt_pkg::S_FINISH : rpt_pkg::S_VLOAD;
            end
          endcase
        end
      end

      // All cells compare against the probe at once.
      rpt_pkg::S_PROBE: begin
        hvec_nxt  = hit & valid;
        bad_nxt   = bad_now;
        state_nxt = rpt_pkg::S_EVAL;
      end

      rpt_pkg::S_EVAL: begin
        case (mode_r)
          rpt_pkg::M_CHECK: begin
            if (!probe_ok) begin
              res_st_nxt  = bad_r ? rpt_pkg::ST_BOUNDS : rpt_pkg::ST_OVERLAP;
              res_mid_nxt = iid_r;
              res_oid_nxt = bad_r ? '0 : first_hit_id;
            end
            state_nxt = rpt_pkg::S_FINISH;
          end
          rpt_pkg::M_PREF: begin
            if (probe_ok) begin
              bx_nxt    = rx_r;
              by_nxt    = ry_r;
              state_nxt = rpt_pkg::S_STORE;
            end else if (rw_r > 0 && rh_r > 0) begin
              gx_nxt    = '0;
              gy_nxt    = '0;
              best_nxt  = '1;
              found_nxt = 1'b0;
              mode_nxt  = rpt_pkg::M_GRID;
              state_nxt = rpt_pkg::S_GRID;
            end else begin
              res_st_nxt = rpt_pkg::ST_OVERLAP;
              state_nxt  = rpt_pkg::S_FINISH;
            end
          end
          rpt_pkg::M_GRID: begin
            // Keep the first spot with the strictly smallest distance.
            if (probe_ok && score_r < best_r) begin
              best_nxt  = score_r;
              bx_nxt    = CW'(gx_r);
              by_nxt    = CW'(gy_r);
              found_nxt = 1'b1;
            end
            gx_nxt    = gx_r + step_e;
            state_nxt = rpt_pkg::S_GRID;
          end
          default: begin
            if (!probe_ok) begin
              res_st_nxt  = bad_r ? rpt_pkg::ST_BOUNDS : rpt_pkg::ST_OVERLAP;
              res_mid_nxt = pr_skip_r;
              res_oid_nxt = bad_r ? '0 : first_hit_id;
              state_nxt   = rpt_pkg::S_FINISH;
            end else if (CNTW'(vidx_r) + CNTW'(1) == count_r) begin
              state_nxt = rpt_pkg::S_FINISH;
            end else begin
              vidx_nxt  = vidx_r + IW'(1);
              state_nxt = rpt_pkg::S_VLOAD;
            end
          end
        endcase
      end

      // Grid walk: row by row, left to right.
      rpt_pkg::S_GRID: begin
        if (gy_r > lim_y) begin
          if (found_r) begin
            state_nxt = rpt_pkg::S_STORE;
          end else begin
            res_st_nxt = rpt_pkg::ST_OVERLAP;
            state_nxt  = rpt_pkg::S_FINISH;
          end
        end else if (gx_r > lim_x) begin
          gx_nxt = '0;
          gy_nxt = gy_r + step_e;
        end else begin
          pr_x_nxt  = CW'(gx_r);
          pr_y_nxt  = CW'(gy_r);
          score_nxt = score_now;
          state_nxt = rpt_pkg::S_PROBE;
        end
      end

      // Validate: fetch the next entry as the probe.
      rpt_pkg::S_VLOAD: begin
        pr_skip_nxt = ent_id[vidx_r];
        pr_x_nxt    = ent_x[vidx_r];
        pr_y_nxt    = ent_y[vidx_r];
        pr_w_nxt    = ent_w[vidx_r];
        pr_h_nxt    = ent_h[vidx_r];
        state_nxt   = rpt_pkg::S_PROBE;
      end

      rpt_pkg::S_RM_FIND: begin
        mvec_nxt  = match & valid;
        state_nxt = rpt_pkg::S_RM_SEL;
      end

      // Remove closes the gap by shifting every later cell left by one.
      rpt_pkg::S_RM_SEL: begin
        res_mid_nxt = iid_r;
        if (rm_any) begin
          shift_en  = 1'b1;
          count_nxt = count_r - CNTW'(1);
        end else begin
          res_st_nxt = rpt_pkg::ST_NOTFOUND;
        end
        state_nxt = rpt_pkg::S_FINISH;
      end

      rpt_pkg::S_STORE: begin
        load_en     = 1'b1;
        count_nxt   = count_r + CNTW'(1);
        res_mid_nxt = nfid_r;
        res_px_nxt  = bx_r[rpt_pkg::PLACE_W-1:0];
        res_py_nxt  = by_r[rpt_pkg::PLACE_W-1:0];
        nfid_nxt    = (nfid_r == rpt_pkg::LAST_ID) ? rpt_pkg::RST_NEXT_ID
                                                   : nfid_r + 16'd1;
        state_nxt   = rpt_pkg::S_FINISH;
      end

      rpt_pkg::S_FINISH: begin
        state_nxt = rpt_pkg::S_IDLE;
      end

      default: begin
        state_nxt = rpt_pkg::S_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= rpt_pkg::S_IDLE;
      mode_r  <= rpt_pkg::M_CHECK;
      count_r <= '0;
      nfid_r  <= rpt_pkg::RST_NEXT_ID;
      sw_r    <= rpt_pkg::RST_SCREEN_WIDTH;
      sh_r    <= rpt_pkg::RST_SCREEN_HEIGHT;
      step_r  <= rpt_pkg::RST_GRID_STEP;
    end else begin
      state_r <= state_nxt;
      mode_r  <= mode_nxt;
      count_r <= count_nxt;
      nfid_r  <= nfid_nxt;
      sw_r    <= sw_nxt;
      sh_r    <= sh_nxt;
      step_r  <= step_nxt;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    iid_r     <= iid_nxt;
    rx_r      <= rx_nxt;
    ry_r      <= ry_nxt;
    rw_r      <= rw_nxt;
    rh_r      <= rh_nxt;
    pr_skip_r <= pr_skip_nxt;
    pr_x_r    <= pr_x_nxt;
    pr_y_r    <= pr_y_nxt;
    pr_w_r    <= pr_w_nxt;
    pr_h_r    <= pr_h_nxt;
    gx_r      <= gx_nxt;
    gy_r      <= gy_nxt;
    score_r   <= score_nxt;
    best_r    <= best_nxt;
    bx_r      <= bx_nxt;
    by_r      <= by_nxt;
    found_r   <= found_nxt;
    vidx_r    <= vidx_nxt;
    hvec_r    <= hvec_nxt;
    mvec_r    <= mvec_nxt;
    bad_r     <= bad_nxt;
    res_st_r  <= res_st_nxt;
    res_mid_r <= res_mid_nxt;
    res_oid_r <= res_oid_nxt;
    res_px_r  <= res_px_nxt;
    res_py_r  <= res_py_nxt;
  end

  // Result beat.
  assign out_valid    = (state_r == rpt_pkg::S_FINISH);
  assign out_status   = res_st_r;
  assign out_rect_id  = res_mid_r;
  assign out_hit_id   = res_oid_r;
  assign out_placed_x = res_px_r;
  assign out_placed_y = res_py_r;

endmodule

// ===== design/rpt_checker.sv =====
`include "rect_placement_table_top_macros.svh"

// Port-level checks on the command and result handshake.
module rpt_checker (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       start,
  input logic                       busy,
  input logic                       out_valid,
  input logic [rpt_pkg::STAT_W-1:0] out_status,
  input logic [rpt_pkg::ID_W-1:0]   out_rect_id
);

  // An accepted command always makes the block busy.
  `RPT_ASSERT_NEXT(a_accept_busy, start && !busy, busy)
  // A result beat lasts one cycle and ends the command.
  `RPT_ASSERT_NEXT(a_beat_single, out_valid, !out_valid && !busy)
  // Results only appear while a command is in flight.
  `RPT_ASSERT_NOW(a_beat_busy, out_valid, busy)
  // Status codes stay inside the defined set, and full-table never names an id.
  `RPT_ASSERT_NOW(a_status_code, out_valid,
                  out_status <= rpt_pkg::ST_NOTFOUND &&
                  (out_status != rpt_pkg::ST_FULL || out_rect_id == '0))

endmodule

bind rect_placement_table_top rpt_checker u_rpt_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .start       (start),
  .busy        (busy),
  .out_valid   (out_valid),
  .out_status  (out_status),
  .out_rect_id (out_rect_id)
);

// ===== tb/tb_top.sv =====
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import rpt_pkg::*;

  // Register index that the block does not decode.
  localparam logic [CIDX_W-1:0] REG_UNUSED = 2'd3;
  localparam int DEPTH = RPT_TABLE_DEPTH;
  localparam int CB    = RPT_COORD_BITS;

  // One expected result beat.
  typedef struct {
    logic [STAT_W-1:0]  status;
    logic [ID_W-1:0]    rect_id;
    logic [ID_W-1:0]    hit_id;
    logic [PLACE_W-1:0] placed_x;
    logic [PLACE_W-1:0] placed_y;
  } outcome_t;

  // Stored rectangle in the predictor.
  typedef struct {
    int unsigned id;
    int          x;
    int          y;
    int          w;
    int          h;
  } slot_t;

  // Placement predictor and result checker.
  class placement_scoreboard;
    slot_t       slots[DEPTH];
    int unsigned count;
    int unsigned next_id;
    int          scr_w;
    int          scr_h;
    int          step;
    outcome_t    pending[$];
    int          errors;

    function new();
      count   = 0;
      next_id = RST_NEXT_ID;
      scr_w   = RST_SCREEN_WIDTH;
      scr_h   = RST_SCREEN_HEIGHT;
      step    = RST_GRID_STEP;
      errors  = 0;
    endfunction

    function void set_reg(logic [CIDX_W-1:0] idx, logic [CFG_W-1:0] val);
      case (idx)
        REG_SCREEN_WIDTH:  scr_w = val;
        REG_SCREEN_HEIGHT: scr_h = val;
        REG_GRID_STEP:     step  = val[STEP_W-1:0];
        default: ;
      endcase
    endfunction

    // Bounds test, then first stored rectangle that crosses the candidate.
    function logic [STAT_W-1:0] probe(int unsigned skip, int x, int y, int w, int h,
                                      output int unsigned hit);
      hit = 0;
      if (x < 0 || y < 0 || w <= 0 || h <= 0 || x + w > scr_w || y + h > scr_h)
        return ST_BOUNDS;
      for (int i = 0; i < count; i++) begin
        if (slots[i].id == skip) continue;
        if (x + w <= slots[i].x || slots[i].x + slots[i].w <= x) continue;
        if (y + h <= slots[i].y || slots[i].y + slots[i].h <= y) continue;
        hit = slots[i].id;
        return ST_OVERLAP;
      end
      return ST_OK;
    endfunction

    function void note_input(logic [CMD_W-1:0] cmd, logic [ID_W-1:0] iid,
                             logic signed [CB-1:0] xs, logic signed [CB-1:0] ys,
                             logic signed [CB-1:0] ws, logic signed [CB-1:0] hs);
      outcome_t    e;
      int          x, y, w, h, bx, by, best, manh, stp;
      int unsigned hit;
      bit          found;
      x = xs; y = ys; w = ws; h = hs;
      e = '{ST_OK, 0, 0, 0, 0};
      case (cmd)
        CMD_CHECK: begin
          e.status = probe(iid, x, y, w, h, hit);
          if (e.status != ST_OK) begin
            e.rect_id = iid;
            e.hit_id  = hit;
          end
        end
        CMD_ADD: begin
          if (count >= DEPTH) begin
            e.status = ST_FULL;
          end else begin
            found = 0; bx = 0; by = 0;
            if (probe(0, x, y, w, h, hit) == ST_OK) begin
              bx = x; by = y; found = 1;
            end else if (w > 0 && h > 0) begin
              // Row-major grid walk, first spot wins on equal distance.
              stp  = (step == 0) ? 1 : step;
              best = 32'h7fffffff;
              for (int gy = 0; gy <= scr_h - h; gy += stp)
                for (int gx = 0; gx <= scr_w - w; gx += stp) begin
                  manh = (gx > x ? gx - x : x - gx) + (gy > y ? gy - y : y - gy);
                  if (probe(0, gx, gy, w, h, hit) != ST_OK) continue;
                  if (manh < best) begin
                    best = manh; bx = gx; by = gy; found = 1;
                  end
                end
            end
            if (!found) begin
              e.status = ST_OVERLAP;
            end else begin
              slots[count] = '{next_id, bx, by, w, h};
              count++;
              e.rect_id  = next_id;
              e.placed_x = bx;
              e.placed_y = by;
              next_id = (next_id >= LAST_ID) ? 1 : next_id + 1;
            end
          end
        end
        CMD_REMOVE: begin
          e.status  = ST_NOTFOUND;
          e.rect_id = iid;
          for (int i = 0; i < count; i++) begin
            if (slots[i].id != iid) continue;
            for (int j = i; j + 1 < count; j++) slots[j] = slots[j+1];
            count--;
            e.status = ST_OK;
            break;
          end
        end
        default: begin
          for (int i = 0; i < count; i++) begin
            e.status = probe(slots[i].id, slots[i].x, slots[i].y, slots[i].w,
                             slots[i].h, hit);
            if (e.status != ST_OK) begin
              e.rect_id = slots[i].id;
              e.hit_id  = hit;
              break;
            end
          end
        end
      endcase
      pending.push_back(e);
    endfunction

    function void check_result(outcome_t got);
      outcome_t e;
      if (pending.size() == 0) begin
        $error("result beat with no expected result waiting");
        errors++;
        return;
      end
      e = pending.pop_front();
      if (got.status !== e.status) begin
        $error("status: expected %0d, got %0d", e.status, got.status); errors++;
      end
      if (got.rect_id !== e.rect_id) begin
        $error("rect_id: expected %0d, got %0d", e.rect_id, got.rect_id); errors++;
      end
      if (got.hit_id !== e.hit_id) begin
        $error("hit_id: expected %0d, got %0d", e.hit_id, got.hit_id); errors++;
      end
      if (got.placed_x !== e.placed_x) begin
        $error("placed_x: expected %0d, got %0d", e.placed_x, got.placed_x); errors++;
      end
      if (got.placed_y !== e.placed_y) begin
        $error("placed_y: expected %0d, got %0d", e.placed_y, got.placed_y); errors++;
      end
    endfunction
  endclass

  logic                clk = 0;
  logic                rst_n = 0;
  logic                start = 0;
  logic                busy;
  logic [CMD_W-1:0]    in_command = CMD_CHECK;
  logic [ID_W-1:0]     in_item_id = '0;
  logic signed [CB-1:0] in_rect_x = '0;
  logic signed [CB-1:0] in_rect_y = '0;
  logic signed [CB-1:0] in_rect_w = '0;
  logic signed [CB-1:0] in_rect_h = '0;
  logic                cfg_we = 0;
  logic [CIDX_W-1:0]   cfg_index = REG_SCREEN_WIDTH;
  logic [CFG_W-1:0]    cfg_wdata = '0;
  logic                out_valid;
  logic [STAT_W-1:0]   out_status;
  logic [ID_W-1:0]     out_rect_id;
  logic [ID_W-1:0]     out_hit_id;
  logic [PLACE_W-1:0]  out_placed_x;
  logic [PLACE_W-1:0]  out_placed_y;

  placement_scoreboard sb = new();
  int idle_pct = 0;

  always #1 clk = ~clk;

  rect_placement_table_top i_dut (
    .clk, .rst_n, .start, .busy,
    .in_command, .in_item_id, .in_rect_x, .in_rect_y, .in_rect_w, .in_rect_h,
    .cfg_we, .cfg_index, .cfg_wdata,
    .out_valid, .out_status, .out_rect_id, .out_hit_id,
    .out_placed_x, .out_placed_y
  );

  // Every result beat is taken at the edge that ends its cycle.
  always @(posedge clk) begin
    if (rst_n && out_valid)
      sb.check_result('{out_status, out_rect_id, out_hit_id,
                        out_placed_x, out_placed_y});
  end

  // Present one command beat and hold it until the block takes it.
  task automatic send(logic [CMD_W-1:0] cmd, int iid, int x, int y, int w, int h);
    if ($urandom_range(99) < idle_pct) begin
      start <= 0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    start      <= 1;
    in_command <= cmd;
    in_item_id <= iid[ID_W-1:0];
    in_rect_x  <= x[CB-1:0];
    in_rect_y  <= y[CB-1:0];
    in_rect_w  <= w[CB-1:0];
    in_rect_h  <= h[CB-1:0];
    do @(posedge clk); while (busy);
    sb.note_input(cmd, iid[ID_W-1:0], x[CB-1:0], y[CB-1:0], w[CB-1:0], h[CB-1:0]);
  endtask

  // Wait until every expected result has come and the block is quiet.
  task automatic drain();
    start <= 0;
    @(posedge clk);
    while (sb.pending.size() != 0 || busy) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(logic [CIDX_W-1:0] idx, int val);
    cfg_we    <= 1;
    cfg_index <= idx;
    cfg_wdata <= val[CFG_W-1:0];
    @(posedge clk);
    cfg_we <= 0;
    sb.set_reg(idx, val[CFG_W-1:0]);
  endtask

  task automatic set_screen(int w, int h, int stp);
    write_reg(REG_SCREEN_WIDTH, w);
    write_reg(REG_SCREEN_HEIGHT, h);
    write_reg(REG_GRID_STEP, stp);
  endtask

  // Mostly well-formed rectangles sized to the screen, some raw noise.
  task automatic random_item();
    int r, iid, x, y, w, h, sw, sh;
    logic [CMD_W-1:0] cmd;
    r  = $urandom_range(99);
    sw = (sb.scr_w > 0) ? sb.scr_w : 1;
    sh = (sb.scr_h > 0) ? sb.scr_h : 1;
    cmd = (r < 40) ? CMD_ADD : (r < 65) ? CMD_REMOVE : (r < 90) ? CMD_CHECK
                                                                 : CMD_VALIDATE;
    if (sb.count > 0 && $urandom_range(99) < 70)
      iid = sb.slots[$urandom_range(sb.count - 1)].id;
    else
      iid = $urandom_range(16'hFFFF);
    if ($urandom_range(99) < 85) begin
      w = $urandom_range(1, (sw / 3 > 1) ? sw / 3 : 1);
      h = $urandom_range(1, (sh / 3 > 1) ? sh / 3 : 1);
      x = $urandom_range(0, sw);
      y = $urandom_range(0, sh);
    end else begin
      x = $urandom; y = $urandom; w = $urandom; h = $urandom;
    end
    send(cmd, iid, x, y, w, h);
  endtask

  // Screen, step and sender idling per random phase.
  int phase_w[8]    = '{64, 2047, 40, 16, 1, 0, 128, 512};
  int phase_h[8]    = '{48, 2047, 24, 16, 1, 0, 96, 300};
  int phase_step[8] = '{4, 255, 1, 0, 1, 3, 8, 16};
  int phase_idle[4] = '{0, 81, 0, 28};

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // Two entries, then a check that ignores the first one's id.
    send(CMD_ADD, 0, 0, 0, 8, 8);
    send(CMD_ADD, 0, 4, 4, 8, 8);     // preferred spot taken: grid search
    send(CMD_CHECK, 1, 0, 0, 16, 16);
    send(CMD_VALIDATE, 0, 0, 0, 0, 0);
    send(CMD_REMOVE, 1, 0, 0, 0, 0);
    send(CMD_REMOVE, 1, 0, 0, 0, 0);  // already gone
    send(CMD_REMOVE, 2, 0, 0, 0, 0);
    drain();

    // Directed extremes at the reset screen.
    send(CMD_CHECK, 16'hFFFF, -2048, 0, 4, 4);
    send(CMD_CHECK, 5, 0, -1, 4, 4);
    send(CMD_CHECK, 5, 0, 0, 0, 4);
    send(CMD_CHECK, 5, 0, 0, 4, -2048);
    send(CMD_CHECK, 0, 2047, 2047, 2047, 2047);
    send(CMD_CHECK, 0, 1020, 596, 4, 4);
    send(CMD_CHECK, 0, 1021, 0, 4, 4);
    send(CMD_ADD, 0, 0, 0, 1024, 600);
    send(CMD_ADD, 0, 0, 0, 4, 4);     // full screen taken: no room
    send(CMD_CHECK, 0, 10, 10, 4, 4);
    send(CMD_REMOVE, 0, 0, 0, 0, 0);
    send(CMD_REMOVE, 16'hABCD, 0, 0, 0, 0);
    send(CMD_REMOVE, sb.slots[0].id, 0, 0, 0, 0);
    send(CMD_ADD, 0, 500, 300, 40, 40);
    send(CMD_ADD, 0, 510, 310, 40, 40);   // grid search from an occupied spot
    for (int i = 0; i < 14; i++) send(CMD_ADD, 0, i * 60, 500, 50, 50);
    send(CMD_ADD, 0, 0, 0, 4, 4);         // table full
    drain();
    write_reg(REG_UNUSED, 12);
    set_screen(2047, 2047, 255);
    set_screen(300, 200, 255);            // shrunk screen: validate flags entries
    send(CMD_VALIDATE, 0, 0, 0, 0, 0);
    drain();

    // Random phases, each starting from the screen it sets.
    for (int p = 0; p < 8; p++) begin
      set_screen(phase_w[p], phase_h[p], phase_step[p]);
      idle_pct = phase_idle[p % 4];
      for (int n = 0; n < 240; n++) begin
        random_item();
        if (n == 120) drain();
      end
      drain();
    end

    repeat (20) @(posedge clk);
    if (sb.errors == 0 && sb.pending.size() == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end

  // Hard limit on the whole run.
  initial begin
    #50ms;
    $display("*** FAILED ***");
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+design
design/rpt_pkg.sv
design/rpt_cell.sv
design/rect_placement_table_top.sv
design/rpt_checker.sv
tb/tb_top.sv
